@@ hw/rtl/mcng_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mcng_pkg
// Shared types, constants and the chord shape table of the chord note
// generator.
// ---------------------------------------------------------------------------
package mcng_pkg;

    localparam int MAX_TONES  = 6;
    localparam int NUM_KINDS  = 18;
    localparam int NOTE_W     = 7;
    localparam int IDX_W      = 3;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 5;

    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHORD_KIND    = 8'd0,
        REG_VOICING_STYLE = 8'd1,
        REG_OCTAVE_SHIFT  = 8'd2
    } cfg_reg_t;

    localparam logic [1:0] VOICING_CLOSE = 2'd0;
    localparam logic [1:0] VOICING_OPEN  = 2'd1;
    localparam logic [1:0] VOICING_WIDE  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]                  count;
        logic [MAX_TONES-1:0][STEP_W-1:0]  step;
    } chord_shape_t;

    function automatic chord_shape_t make_shape(
        input logic [IDX_W-1:0]  count,
        input logic [STEP_W-1:0] s0,
        input logic [STEP_W-1:0] s1,
        input logic [STEP_W-1:0] s2,
        input logic [STEP_W-1:0] s3,
        input logic [STEP_W-1:0] s4,
        input logic [STEP_W-1:0] s5
    );
        chord_shape_t shape;
        shape.count   = count;
        shape.step[0] = s0;
        shape.step[1] = s1;
        shape.step[2] = s2;
        shape.step[3] = s3;
        shape.step[4] = s4;
        shape.step[5] = s5;
        return shape;
    endfunction

    // Unknown chord types have no intervals and therefore keep no tone.
    function automatic chord_shape_t chord_shape(input logic [4:0] kind);
        chord_shape_t shape;
        case (kind)
            5'd0:    shape = make_shape(3'd3, 5'd0, 5'd4, 5'd7, 5'd0, 5'd0, 5'd0);
            5'd1:    shape = make_shape(3'd3, 5'd0, 5'd3, 5'd7, 5'd0, 5'd0, 5'd0);
            5'd2:    shape = make_shape(3'd4, 5'd0, 5'd4, 5'd7, 5'd11, 5'd0, 5'd0);
            5'd3:    shape = make_shape(3'd4, 5'd0, 5'd3, 5'd7, 5'd10, 5'd0, 5'd0);
            5'd4:    shape = make_shape(3'd4, 5'd0, 5'd4, 5'd7, 5'd10, 5'd0, 5'd0);
            5'd5:    shape = make_shape(3'd3, 5'd0, 5'd3, 5'd6, 5'd0, 5'd0, 5'd0);
            5'd6:    shape = make_shape(3'd3, 5'd0, 5'd4, 5'd8, 5'd0, 5'd0, 5'd0);
            5'd7:    shape = make_shape(3'd3, 5'd0, 5'd2, 5'd7, 5'd0, 5'd0, 5'd0);
            5'd8:    shape = make_shape(3'd3, 5'd0, 5'd5, 5'd7, 5'd0, 5'd0, 5'd0);
            5'd9:    shape = make_shape(3'd4, 5'd0, 5'd4, 5'd7, 5'd9, 5'd0, 5'd0);
            5'd10:   shape = make_shape(3'd4, 5'd0, 5'd3, 5'd7, 5'd9, 5'd0, 5'd0);
            5'd11:   shape = make_shape(3'd5, 5'd0, 5'd4, 5'd7, 5'd11, 5'd14, 5'd0);
            5'd12:   shape = make_shape(3'd5, 5'd0, 5'd3, 5'd7, 5'd10, 5'd14, 5'd0);
            5'd13:   shape = make_shape(3'd5, 5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd0);
            5'd14:   shape = make_shape(3'd6, 5'd0, 5'd4, 5'd7, 5'd11, 5'd14, 5'd17);
            5'd15:   shape = make_shape(3'd6, 5'd0, 5'd3, 5'd7, 5'd10, 5'd14, 5'd17);
            5'd16:   shape = make_shape(3'd6, 5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd17);
            5'd17:   shape = make_shape(3'd5, 5'd0, 5'd4, 5'd7, 5'd9, 5'd14, 5'd0);
            default: shape = make_shape(3'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
        endcase
        return shape;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/midi_chord_note_generator.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// midi_chord_note_generator
// Turns a MIDI root note into the tones of the configured chord, one tone
// per output item, with voicing, octave shift and range filtering.
// ---------------------------------------------------------------------------
// A root note of a chord that keeps n tones yields n output items (a single
// empty item when no tone is kept). The output register passes one tone per
// cycle out of the tone buffer while out_stall does not hold it; the next
// root is taken in the same cycle as the last tone of the current one leaves
// the buffer.
module midi_chord_note_generator (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [mcng_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [mcng_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire  [mcng_pkg::NOTE_W-1:0]       root_note,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [mcng_pkg::NOTE_W-1:0]       note_value,
    output logic [mcng_pkg::IDX_W-1:0]        tone_index,
    output logic                              last_tone,
    output logic                              no_tones
);
    import mcng_pkg::*;

    logic [4:0]        chord_kind_reg;
    logic [1:0]        voicing_style_reg;
    logic signed [2:0] octave_shift_reg;

    logic              buf_busy_reg;
    logic [NOTE_W-1:0] buf_note_reg [MAX_TONES];
    logic [IDX_W-1:0]  buf_cnt_reg;
    logic [IDX_W-1:0]  buf_idx_reg;
    logic              buf_empty_reg;

    logic              out_valid_reg;
    logic [NOTE_W-1:0] note_value_reg;
    logic [IDX_W-1:0]  tone_index_reg;
    logic              last_tone_reg;
    logic              no_tones_reg;

    chord_shape_t      shape;
    logic signed [8:0] octave_offset;
    logic signed [8:0] raw_note [MAX_TONES];
    logic [MAX_TONES-1:0] keep;
    logic [NOTE_W-1:0] kept_note [MAX_TONES];
    logic [IDX_W-1:0]  kept_cnt;
    logic [7:0]        voiced [MAX_TONES];
    logic [NOTE_W-1:0] final_note [MAX_TONES];

    logic              in_accept;
    logic              move;
    logic              buf_last;
    logic              buf_busy_next;
    logic [IDX_W-1:0]  buf_idx_next;
    logic              out_valid_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chord_kind_reg    <= '0;
            voicing_style_reg <= VOICING_CLOSE;
            octave_shift_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHORD_KIND:    chord_kind_reg    <= cfg_data[4:0];
                REG_VOICING_STYLE: voicing_style_reg <= cfg_data[1:0];
                REG_OCTAVE_SHIFT:
                begin
                    if (cfg_data[2:0] == 3'b100)
                        octave_shift_reg <= -3'sd3;
                    else
                        octave_shift_reg <= $signed(cfg_data[2:0]);
                end
                default: ;
            endcase
        end
    end

    // Tone list of the incoming root.
    always_comb
    begin
        logic [IDX_W-1:0] pos;
        shape         = chord_shape(chord_kind_reg);
        octave_offset = 9'(octave_shift_reg) * 9'sd12;
        pos           = '0;
        for (int i = 0; i < MAX_TONES; i++)
        begin
            raw_note[i]  = $signed({2'b00, root_note}) + octave_offset
                         + $signed({4'b0000, shape.step[i]});
            keep[i]      = (IDX_W'(i) < shape.count) && (raw_note[i][8:7] == 2'b00);
            kept_note[i] = '0;
        end
        for (int i = 0; i < MAX_TONES; i++)
        begin
            if (keep[i])
            begin
                kept_note[pos] = raw_note[i][NOTE_W-1:0];
                pos            = pos + 1'b1;
            end
        end
        kept_cnt = pos;

        for (int i = 0; i < MAX_TONES; i++)
            voiced[i] = {1'b0, kept_note[i]};
        if (voicing_style_reg == VOICING_OPEN)
        begin
            if (kept_cnt >= 3'd3)
                voiced[1] = voiced[1] + 8'd12;
        end
        else if (voicing_style_reg == VOICING_WIDE)
        begin
            if (kept_cnt >= 3'd2)
                voiced[1] = voiced[1] + 8'd12;
            if (kept_cnt >= 3'd3)
                voiced[2] = voiced[2] + 8'd24;
        end
        for (int i = 0; i < MAX_TONES; i++)
            final_note[i] = voiced[i][7] ? NOTE_MAX : voiced[i][NOTE_W-1:0];
    end

    // Buffer and output handshake.
    always_comb
    begin
        move      = buf_busy_reg && (!out_valid_reg || !out_stall);
        buf_last  = (buf_idx_reg == buf_cnt_reg - 1'b1);
        in_stall  = buf_busy_reg && !(move && buf_last);
        in_accept = in_valid && !in_stall;

        buf_busy_next = buf_busy_reg;
        buf_idx_next  = buf_idx_reg;
        if (move)
        begin
            buf_idx_next = buf_idx_reg + 1'b1;
            if (buf_last)
                buf_busy_next = 1'b0;
        end
        if (in_accept)
        begin
            buf_busy_next = 1'b1;
            buf_idx_next  = '0;
        end

        if (move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_busy_reg  <= 1'b0;
            buf_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_busy_reg  <= buf_busy_next;
            buf_idx_reg   <= buf_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < MAX_TONES; i++)
                buf_note_reg[i] <= final_note[i];
            buf_empty_reg <= (kept_cnt == '0);
            buf_cnt_reg   <= (kept_cnt == '0) ? IDX_W'(1) : kept_cnt;
        end
        if (move)
        begin
            note_value_reg <= buf_empty_reg ? '0 : buf_note_reg[buf_idx_reg];
            tone_index_reg <= buf_idx_reg;
            last_tone_reg  <= buf_last;
            no_tones_reg   <= buf_empty_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign note_value = note_value_reg;
    assign tone_index = tone_index_reg;
    assign last_tone  = last_tone_reg;
    assign no_tones   = no_tones_reg;

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_tones) |-> (last_tone && note_value == '0 && tone_index == '0))
        else $error("empty item is not a lone final item");

    a_chord_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_tone) |=> out_valid)
        else $error("chord broken off before its last tone");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_tone) |=>
            (tone_index == $past(tone_index) + 1'b1))
        else $error("tone index did not advance by one");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> buf_busy_reg)
        else $error("accepted root did not fill the tone buffer");

endmodule
`default_nettype wire
